/* rtl/sbmm_pkg.sv */
// Shared constants and control types for the segmented bus memory model.
package sbmm_pkg;

   localparam int ADDR_W = 15;
   localparam int DATA_W = 8;
   localparam int CNT_W  = 7;
   localparam int MARK_W = 2;
   localparam int WORD_W = MARK_W + DATA_W;
   localparam int BOUND_W = 17;

   localparam int MEM_BYTES_DEFAULT     = 16384;
   localparam int SEG_BYTES_DEFAULT     = 64;
   localparam int DEBUG_SEG_DEFAULT     = 4;
   localparam int TIMEOUT_CYCLE_DEFAULT = 100;

   localparam logic [MARK_W-1:0] MARK_UNINIT = 2'd0;
   localparam logic [MARK_W-1:0] MARK_ROM    = 2'd1;
   localparam logic [MARK_W-1:0] MARK_RAM    = 2'd2;

   localparam logic [DATA_W-1:0] UNINIT_VALUE = 8'hCC;
   localparam logic [DATA_W-1:0] DEBUG_CMD_OK = 8'd2;

   localparam logic CMD_BUS     = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;   // write one cleared mark and advance the sweep
      logic take;       // accept a request transfer this cycle
      logic finish;     // resolve the held bus cycle and load the response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;   // sweep is at its final entry
      logic rsp_blocked;  // response register full and stalled
   } status_type;

endpackage

/* rtl/sbmm_ctrl.sv */
// Controller: clearing pass, request acceptance and bus cycle sequencing.
module sbmm_ctrl
   import sbmm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_cmd,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_LOOK  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.clear_en = 1'b0;
      cmd.take     = 1'b0;
      cmd.finish   = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.take = req_valid;
            // preloads finish in the accept cycle
            if (req_valid && req_cmd == CMD_BUS) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (!status.rsp_blocked) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/sbmm_datapath.sv */
// Datapath: byte memory with marks, request hold, timeout counter and response register.
module sbmm_datapath
   import sbmm_pkg::*;
#(
   parameter int MEM_BYTES     = MEM_BYTES_DEFAULT,
   parameter int SEG_BYTES     = SEG_BYTES_DEFAULT,
   parameter int DEBUG_SEG     = DEBUG_SEG_DEFAULT,
   parameter int TIMEOUT_CYCLE = TIMEOUT_CYCLE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              req_cmd,
   input  logic [ADDR_W-1:0] req_addr,
   input  logic [DATA_W-1:0] req_data,
   input  logic              req_write_n,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_bus_error,
   output logic              rsp_reset_n
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam int DBG_LO = DEBUG_SEG * SEG_BYTES;
   localparam int DBG_HI = (DEBUG_SEG + 1) * SEG_BYTES;

   logic [WORD_W-1:0] mem [MEM_BYTES];

   logic [AW-1:0]     clr_ff;
   logic [AW-1:0]     clr_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [DATA_W-1:0] data_ff;
   logic              wr_ff;
   logic [WORD_W-1:0] word_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] rd_ff;
   logic [DATA_W-1:0] rd_in;
   logic              err_ff;
   logic              err_in;

   logic              we;
   logic [AW-1:0]     wa;
   logic [WORD_W-1:0] wd;
   logic              req_in_range;
   logic              in_range;
   logic              is_dbg;
   logic              dbg_base;
   logic [MARK_W-1:0] mark;
   logic [BOUND_W-1:0] addr_ext;
   logic [BOUND_W-1:0] req_addr_ext;

   assign addr_ext     = BOUND_W'(addr_ff);
   assign req_addr_ext = BOUND_W'(req_addr);
   assign req_in_range = req_addr_ext < BOUND_W'(MEM_BYTES);
   assign in_range     = addr_ext < BOUND_W'(MEM_BYTES);
   assign is_dbg       = (addr_ext >= BOUND_W'(DBG_LO)) && (addr_ext < BOUND_W'(DBG_HI));
   assign dbg_base     = addr_ext == BOUND_W'(DBG_LO);
   assign mark         = word_ff[WORD_W-1:DATA_W];

   assign status.clear_last  = clr_ff == AW'(MEM_BYTES - 1);
   assign status.rsp_blocked = rsp_valid_ff && rsp_stall;

   always_comb begin
      we           = 1'b0;
      wa           = AW'(addr_ff);
      wd           = {MARK_RAM, data_ff};
      rd_in        = rd_ff;
      err_in       = err_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.clear_en) begin
         we     = 1'b1;
         wa     = clr_ff;
         wd     = {MARK_UNINIT, {DATA_W{1'b0}}};
         clr_in = clr_ff + AW'(1);
      end

      if (cmd.take && req_cmd == CMD_PRELOAD && req_in_range) begin
         we = 1'b1;
         wa = AW'(req_addr);
         wd = {MARK_ROM, req_data};
      end

      if (cmd.finish) begin
         rd_in  = '0;
         err_in = 1'b0;
         if (in_range) begin
            if (is_dbg) begin
               err_in = !(dbg_base && wr_ff && data_ff == DEBUG_CMD_OK);
            end else if (wr_ff) begin
               if (mark == MARK_ROM) begin
                  err_in = 1'b1;
               end else begin
                  we = 1'b1;
               end
            end else if (mark == MARK_UNINIT) begin
               rd_in = UNINIT_VALUE;
            end else begin
               rd_in = word_ff[DATA_W-1:0];
            end
         end
         // timeout fires once, on the cycle that reaches the limit
         if (cnt_ff < CNT_W'(TIMEOUT_CYCLE)) begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TIMEOUT_CYCLE - 1)) begin
               err_in = 1'b1;
            end
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (cmd.take) begin
         word_ff <= mem[AW'(req_addr)];
         addr_ff <= req_addr;
         data_ff <= req_data;
         wr_ff   <= !req_write_n;
      end
      rd_ff  <= rd_in;
      err_ff <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rd_ff;
   assign rsp_bus_error = err_ff;
   assign rsp_reset_n   = 1'b1;

endmodule

/* rtl/segmented_bus_memory_model_unit.sv */
// Top level of the segmented bus memory model: a bus target for a small CPU.
//
// After reset the block runs a clearing pass over all MEM_BYTES bytes (16384 at
// the default size), marking every byte uninitialised; req_stall stays high
// until it ends. A bus cycle (req_cmd 0) has an accept step, which reads the
// addressed byte and its mark from the one-read, one-write memory into a
// register, and a later resolve step, which resolves the access, performs any
// write and loads the response register. A preload (req_cmd 1) stores a ROM
// byte in its accept cycle and gives no response. The response register holds
// a result while rsp_stall is high, and the next request can be accepted
// meanwhile; a second bus cycle waits in its resolve step until that register
// frees up.
// Segment DEBUG_SEG (SEG_BYTES bytes each) is a debug port: only a write of
// command 2 to its first byte is clean; everything else there flags an error.
// Writes to ROM bytes flag an error, uninitialised bytes read 0xCC, addresses
// at or beyond MEM_BYTES read zero silently, and the TIMEOUT_CYCLE-th bus
// cycle after reset raises rsp_bus_error once. rsp_reset_n is always 1.
module segmented_bus_memory_model_unit
   import sbmm_pkg::*;
#(
   parameter int MEM_BYTES     = MEM_BYTES_DEFAULT,
   parameter int SEG_BYTES     = SEG_BYTES_DEFAULT,
   parameter int DEBUG_SEG     = DEBUG_SEG_DEFAULT,
   parameter int TIMEOUT_CYCLE = TIMEOUT_CYCLE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request channel: one transfer is a bus cycle or a preload
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic [ADDR_W-1:0] req_addr,
   input  logic [DATA_W-1:0] req_data,
   input  logic              req_write_n,
   // response channel: one transfer per bus cycle
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_bus_error,
   output logic              rsp_reset_n
);

   cmd_type    cmd;
   status_type status;

   // sequence the clearing pass and each bus cycle
   sbmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the memory, the timeout counter and the response register
   sbmm_datapath #(
      .MEM_BYTES     (MEM_BYTES),
      .SEG_BYTES     (SEG_BYTES),
      .DEBUG_SEG     (DEBUG_SEG),
      .TIMEOUT_CYCLE (TIMEOUT_CYCLE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_cmd       (req_cmd),
      .req_addr      (req_addr),
      .req_data      (req_data),
      .req_write_n   (req_write_n),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_bus_error (rsp_bus_error),
      .rsp_reset_n   (rsp_reset_n)
   );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the segmented bus memory model unit.
`timescale 1ns / 1ps

module testbench;
   import sbmm_pkg::*;

   localparam int MEM_BYTES     = MEM_BYTES_DEFAULT;
   localparam int SEG_BYTES     = SEG_BYTES_DEFAULT;
   localparam int DEBUG_SEG     = DEBUG_SEG_DEFAULT;
   localparam int TIMEOUT_CYCLE = TIMEOUT_CYCLE_DEFAULT;
   localparam int DEBUG_BASE    = DEBUG_SEG * SEG_BYTES;

   // The clearing pass after reset keeps req_stall high while it sweeps every byte,
   // so the watchdog allows for it plus long random stalls.
   localparam int WATCHDOG_LIMIT = 4 * MEM_BYTES + 2000;
   // After the last response, let the block settle before the summary.
   localparam int TAIL_CYCLES    = 16;
   localparam int PHASE_ITEMS    = 375;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              write_n;
   } bus_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              bus_error;
      logic              reset_n;
   } bus_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_cmd = CMD_BUS;
   logic [ADDR_W-1:0] req_addr = '0;
   logic [DATA_W-1:0] req_data = '0;
   logic              req_write_n = 1'b1;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_bus_error;
   logic              rsp_reset_n;

   segmented_bus_memory_model_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_addr      (req_addr),
      .req_data      (req_data),
      .req_write_n   (req_write_n),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_bus_error (rsp_bus_error),
      .rsp_reset_n   (rsp_reset_n)
   );

   always #4 clock = ~clock;

   // Shadow copy of the target: byte contents, byte marks, bus cycle count.
   logic [DATA_W-1:0] shadow_bytes [MEM_BYTES];
   logic [MARK_W-1:0] shadow_marks [MEM_BYTES];
   logic [CNT_W-1:0]  bus_cycles_seen = '0;

   bus_item_type item_queue [$];      // transfers waiting to be driven
   bus_rsp_type  expected_rsps [$];   // responses predicted, oldest first
   bus_item_type item_in_flight;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int burst_left     = 0;

   int queued_items    = 0;
   int accepted_items  = 0;
   int bus_cycle_count = 0;
   int preload_count   = 0;
   int checked_count   = 0;
   int error_rsp_count = 0;
   int mismatch_count  = 0;
   int quiet_cycles    = 0;

   // Apply one accepted transfer to the shadow and queue the response it owes.
   task automatic predict_transfer(input bus_item_type it);
      bus_rsp_type rsp;
      int unsigned a;
      logic        err;
      logic [DATA_W-1:0] rd;
      a   = it.addr;
      err = 1'b0;
      rd  = '0;
      if (it.cmd == CMD_PRELOAD) begin
         // preloads beyond memory vanish; inside they overwrite any mark
         if (a < MEM_BYTES) begin
            shadow_bytes[a] = it.data;
            shadow_marks[a] = MARK_ROM;
         end
         preload_count++;
         return;
      end
      bus_cycle_count++;
      if (a < MEM_BYTES) begin
         if (a / SEG_BYTES == DEBUG_SEG) begin
            // debug port: only a write of the OK command at offset 0 is clean
            err = (a % SEG_BYTES != 0) || it.write_n || (it.data != DEBUG_CMD_OK);
         end else if (!it.write_n) begin
            if (shadow_marks[a] == MARK_ROM) begin
               err = 1'b1;
            end else begin
               shadow_bytes[a] = it.data;
               shadow_marks[a] = MARK_RAM;
            end
         end else begin
            rd = (shadow_marks[a] == MARK_UNINIT) ? UNINIT_VALUE : shadow_bytes[a];
         end
         if (err) begin
            rd = '0;
         end
      end
      // the counter saturates, so the timeout flag fires once per reset
      if (bus_cycles_seen < TIMEOUT_CYCLE) begin
         bus_cycles_seen++;
         if (bus_cycles_seen == TIMEOUT_CYCLE) begin
            err = 1'b1;
         end
      end
      rsp.read_data = rd;
      rsp.bus_error = err;
      rsp.reset_n   = 1'b1;
      expected_rsps.push_back(rsp);
   endtask

   task automatic queue_item(input logic cmd, input int addr, input int data,
                             input logic write_n);
      bus_item_type it;
      it.cmd     = cmd;
      it.addr    = addr[ADDR_W-1:0];
      it.data    = data[DATA_W-1:0];
      it.write_n = write_n;
      item_queue.push_back(it);
      queued_items++;
   endtask

   // Random transfer: mostly a small hot window so that writes, preloads and
   // reads land on the same bytes; the rest covers debug, full and beyond.
   function automatic bus_item_type random_item();
      bus_item_type it;
      int           pick;
      pick       = $urandom_range(0, 99);
      it.cmd     = CMD_BUS;
      it.data    = DATA_W'($urandom);
      it.write_n = 1'($urandom);
      if (pick < 12) begin
         it.cmd  = CMD_PRELOAD;
         it.addr = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom)
                                                : ADDR_W'($urandom_range(0, 127));
      end else if (pick < 28) begin
         it.addr = ADDR_W'(DEBUG_BASE +
                           (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 63)));
         if ($urandom_range(0, 1) == 0) begin
            it.data = DEBUG_CMD_OK;
         end
      end else if (pick < 36) begin
         it.addr = ADDR_W'($urandom_range(MEM_BYTES, 32767));
      end else if (pick < 46) begin
         it.addr = ADDR_W'($urandom_range(0, MEM_BYTES - 1));
      end else begin
         it.addr = ADDR_W'($urandom_range(0, 127));
      end
      return it;
   endfunction

   // Driver: advance to the next transfer once the current one is taken.
   always @(posedge clock) begin : drive_proc
      bus_item_type nxt;
      int           idle_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_transfer(item_in_flight);
            accepted_items++;
         end
         if (!req_valid || !req_stall) begin
            idle_pct = (burst_left != 0) ? 0 : send_idle_pct;
            if (item_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               nxt            = item_queue.pop_front();
               item_in_flight = nxt;
               req_valid     <= 1'b1;
               req_cmd       <= nxt.cmd;
               req_addr      <= nxt.addr;
               req_data      <= nxt.data;
               req_write_n   <= nxt.write_n;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Occasional stretches in which neither side idles.
   always @(posedge clock) begin
      if (burst_left != 0) begin
         burst_left <= burst_left - 1;
      end else if ($urandom_range(0, 63) == 0) begin
         burst_left <= 30;
      end
   end

   // Receiver: stall at random, never during reset.
   always @(posedge clock) begin
      if (reset || burst_left != 0) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Monitor: check each response transfer against the oldest prediction.
   always @(posedge clock) begin : check_proc
      bus_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response read_data=%0h bus_error=%0b reset_n=%0b",
                     $time, rsp_read_data, rsp_bus_error, rsp_reset_n);
         end else begin
            want = expected_rsps.pop_front();
            checked_count++;
            if (rsp_bus_error) begin
               error_rsp_count++;
            end
            if (rsp_read_data !== want.read_data) begin
               mismatch_count++;
               $display("%0t: read_data expected %0h actual %0h",
                        $time, want.read_data, rsp_read_data);
            end
            if (rsp_bus_error !== want.bus_error) begin
               mismatch_count++;
               $display("%0t: bus_error expected %0b actual %0b",
                        $time, want.bus_error, rsp_bus_error);
            end
            if (rsp_reset_n !== want.reset_n) begin
               mismatch_count++;
               $display("%0t: reset_n expected %0b actual %0b",
                        $time, want.reset_n, rsp_reset_n);
            end
         end
      end
   end

   // Watchdog: drop the run if no transfer moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d responses still awaited",
                     $time, expected_rsps.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic run_phase(input int idle, input int stall);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (PHASE_ITEMS) begin
         item_queue.push_back(random_item());
         queued_items++;
      end
      while (item_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      for (int i = 0; i < MEM_BYTES; i++) begin
         shadow_bytes[i] = '0;
         shadow_marks[i] = MARK_UNINIT;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: ROM preload, read back, and a write that must bounce off it.
      queue_item(CMD_PRELOAD, 16'h0010, 8'hA5, 1'b1);
      queue_item(CMD_BUS,     16'h0010, 8'h00, 1'b1);
      queue_item(CMD_BUS,     16'h0010, 8'h5A, 1'b0);
      // uninitialised read, RAM write and read back, zero data
      queue_item(CMD_BUS,     16'h0011, 8'hFF, 1'b1);
      queue_item(CMD_BUS,     16'h0011, 8'hFF, 1'b0);
      queue_item(CMD_BUS,     16'h0011, 8'h00, 1'b1);
      queue_item(CMD_BUS,     16'h0012, 8'h00, 1'b0);
      queue_item(CMD_BUS,     16'h0012, 8'hFF, 1'b1);
      // preload over a RAM byte turns it into ROM
      queue_item(CMD_PRELOAD, 16'h0011, 8'h3C, 1'b0);
      queue_item(CMD_BUS,     16'h0011, 8'h00, 1'b1);
      queue_item(CMD_BUS,     16'h0011, 8'h77, 1'b0);
      // debug port: clean command, bad command, bad offset, reads
      queue_item(CMD_BUS, DEBUG_BASE,      DEBUG_CMD_OK, 1'b0);
      queue_item(CMD_BUS, DEBUG_BASE,      8'h03,        1'b0);
      queue_item(CMD_BUS, DEBUG_BASE + 1,  DEBUG_CMD_OK, 1'b0);
      queue_item(CMD_BUS, DEBUG_BASE,      DEBUG_CMD_OK, 1'b1);
      queue_item(CMD_BUS, DEBUG_BASE + 63, 8'hFF,        1'b1);
      // beyond memory: silent writes, zero reads, ignored preload
      queue_item(CMD_BUS,     16'h7FFF, 8'hFF, 1'b0);
      queue_item(CMD_BUS,     16'h7FFF, 8'h00, 1'b1);
      queue_item(CMD_BUS,     MEM_BYTES, 8'h00, 1'b1);
      queue_item(CMD_PRELOAD, 16'h5000, 8'h99, 1'b1);
      queue_item(CMD_BUS,     16'h5000, 8'h00, 1'b1);
      // last byte inside memory and the first one
      queue_item(CMD_BUS, MEM_BYTES - 1, 8'h80, 1'b0);
      queue_item(CMD_BUS, MEM_BYTES - 1, 8'h00, 1'b1);
      queue_item(CMD_BUS, 0,             8'h00, 1'b1);
      while (item_queue.size() != 0) begin
         @(posedge clock);
      end

      // Random traffic under each idling pattern; the timeout cycle lands early.
      run_phase(0, 0);
      run_phase(80, 0);
      run_phase(0, 80);
      run_phase(24, 24);

      while (accepted_items != queued_items) begin
         @(posedge clock);
      end
      while (expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d transfers: %0d bus cycles and %0d ROM preloads",
               accepted_items, bus_cycle_count, preload_count);
      $display("checked %0d responses, %0d of them flagged bus errors, %0d mismatches",
               checked_count, error_rsp_count, mismatch_count);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/sbmm_pkg.sv
rtl/sbmm_ctrl.sv
rtl/sbmm_datapath.sv
rtl/segmented_bus_memory_model_unit.sv
tb/testbench.sv
